@@ rtl/tgq_pkg.sv @@
// ---------------------------------------------------------------------------
// tgq_pkg - shared types and constants of the text glyph quad generator
// glyph entry layout, request mode codes, register indexes, vertex order
// ---------------------------------------------------------------------------
package tgq_pkg;

  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 32;

  // request kinds on the input channel
  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_CHAR  = 1'b1
  } mode_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ORIGIN_X    = 2'd0,
    REG_ORIGIN_Y    = 2'd1,
    REG_LINE_HEIGHT = 2'd2,
    REG_TEXT_COLOR  = 2'd3
  } cfg_reg_t;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [15:0] V_ZERO       = 16'd0;
  localparam logic [15:0] V_ONE        = 16'd32768;

  localparam logic [15:0] ORIGIN_X_RESET    = 16'd8;
  localparam logic [15:0] ORIGIN_Y_RESET    = 16'd8;
  localparam logic [7:0]  LINE_HEIGHT_RESET = 8'd16;
  localparam logic [31:0] TEXT_COLOR_RESET  = 32'hFFFF_FFFF;

  localparam logic [2:0] LAST_VERTEX = 3'd5;

  typedef struct packed {
    logic [7:0]  advance;
    logic [15:0] u_right;
    logic [15:0] u_left;
  } glyph_entry_t;

  // which corner a vertex sits on: u follows the column, v follows the row
  typedef struct packed {
    logic right;
    logic bottom;
  } corner_t;

  function automatic corner_t vertex_corner(logic [2:0] idx);
    corner_t c;
    case (idx)
      3'd0: c = '{right: 1'b0, bottom: 1'b0};
      3'd1: c = '{right: 1'b1, bottom: 1'b0};
      3'd2: c = '{right: 1'b1, bottom: 1'b1};
      3'd3: c = '{right: 1'b0, bottom: 1'b0};
      3'd4: c = '{right: 1'b1, bottom: 1'b1};
      3'd5: c = '{right: 1'b0, bottom: 1'b1};
      default: c = '{right: 1'b0, bottom: 1'b0};
    endcase
    return c;
  endfunction

endpackage

@@ rtl/text_glyph_quad_generator.sv @@
// ---------------------------------------------------------------------------
// text_glyph_quad_generator - bitmap font text to textured quads
// keeps a glyph table and a pen; each drawn character gives six vertices
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake          carries
//  in_*      in         in_valid/in_ready  glyph load or text character
//  out_*     out        out_valid/out_ready one vertex per request
//  cfg_*     in         cfg_we             origin, line height, color
//
// a drawn glyph occupies the vertex emitter until its sixth vertex is taken,
// one vertex per accepted output request; loads, newlines and skipped
// characters pass the read stage without waiting for the emitter. the first
// vertex is shown after the glyph table read and then the emitter load.
// reset (rst_n low, synchronous) clears all valid bits, the pen and the
// pipeline, and loads the register defaults; no clearing pass is needed.
// a stalled output holds the emitter; a new character still enters the
// read stage, so the next glyph starts right after the sixth vertex.
//
module text_glyph_quad_generator #(
  parameter int unsigned GLYPH_ENTRIES = 256,
  parameter int unsigned COORD_BITS    = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_mode,
  input  logic [7:0]                         in_char_code,
  input  logic                               in_string_start,
  input  logic [15:0]                        in_glyph_u_left,
  input  logic [15:0]                        in_glyph_u_right,
  input  logic [7:0]                         in_glyph_advance,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [15:0]                 out_vertex_x,
  output logic signed [15:0]                 out_vertex_y,
  output logic [15:0]                        out_tex_u,
  output logic [15:0]                        out_tex_v,
  output logic [31:0]                        out_vertex_color,
  output logic                               out_last,

  input  logic                               cfg_we,
  input  logic [tgq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tgq_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int unsigned IDX_BITS = $clog2(GLYPH_ENTRIES);
  localparam logic [8:0]  ENTRY_LIMIT = 9'(GLYPH_ENTRIES);

  // coordinate to 16-bit output field: zero-extend, keep low 16 bits
  function automatic logic [15:0] to_out(logic [COORD_BITS-1:0] c);
    logic [31:0] t;
    t = 32'(c);
    return t[15:0];
  endfunction

  // ------------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------------
  logic [15:0] origin_x_r;
  logic [15:0] origin_y_r;
  logic [7:0]  line_height_r;
  logic [31:0] text_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= tgq_pkg::ORIGIN_X_RESET;
      origin_y_r    <= tgq_pkg::ORIGIN_Y_RESET;
      line_height_r <= tgq_pkg::LINE_HEIGHT_RESET;
      text_color_r  <= tgq_pkg::TEXT_COLOR_RESET;
    end else if (cfg_we) begin
      case (tgq_pkg::cfg_reg_t'(cfg_index))
        tgq_pkg::REG_ORIGIN_X:    origin_x_r    <= cfg_wdata[15:0];
        tgq_pkg::REG_ORIGIN_Y:    origin_y_r    <= cfg_wdata[15:0];
        tgq_pkg::REG_LINE_HEIGHT: line_height_r <= cfg_wdata[7:0];
        tgq_pkg::REG_TEXT_COLOR:  text_color_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // origins sign-extended into the pen's coordinate width
  logic [31:0]           origin_x_ext;
  logic [31:0]           origin_y_ext;
  logic [COORD_BITS-1:0] origin_x_c;
  logic [COORD_BITS-1:0] origin_y_c;

  assign origin_x_ext = {{16{origin_x_r[15]}}, origin_x_r};
  assign origin_y_ext = {{16{origin_y_r[15]}}, origin_y_r};
  assign origin_x_c   = origin_x_ext[COORD_BITS-1:0];
  assign origin_y_c   = origin_y_ext[COORD_BITS-1:0];

  // ------------------------------------------------------------------------
  // input accept, glyph table write and read
  // ------------------------------------------------------------------------
  logic                in_fire;
  logic                in_range;
  logic [IDX_BITS-1:0] in_idx;
  logic                tbl_we;

  assign in_fire  = in_valid && in_ready;
  assign in_range = {1'b0, in_char_code} < ENTRY_LIMIT;
  assign in_idx   = in_char_code[IDX_BITS-1:0];
  assign tbl_we   = in_fire && (in_mode == tgq_pkg::MODE_WRITE) && in_range;

  tgq_pkg::glyph_entry_t glyph_mem [GLYPH_ENTRIES];
  tgq_pkg::glyph_entry_t rd_entry_r;
  logic [GLYPH_ENTRIES-1:0] glyph_valid_r;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      glyph_mem[in_idx] <= '{advance: in_glyph_advance,
                             u_right: in_glyph_u_right,
                             u_left:  in_glyph_u_left};
    end
  end

  // registered read; the read is always for an earlier write edge
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_entry_r <= glyph_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_valid_r <= '0;
    end else if (tbl_we) begin
      glyph_valid_r[in_idx] <= 1'b1;
    end
  end

  // ------------------------------------------------------------------------
  // read stage: one request waiting for the pen and the emitter
  // ------------------------------------------------------------------------
  logic       s1_valid_r;
  logic       s1_mode_r;
  logic [7:0] s1_code_r;
  logic       s1_start_r;
  logic       s1_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r  <= in_mode;
      s1_code_r  <= in_char_code;
      s1_start_r <= in_string_start;
      s1_hit_r   <= in_range && glyph_valid_r[in_idx];
    end
  end

  // ------------------------------------------------------------------------
  // pen update and quad setup
  // ------------------------------------------------------------------------
  logic [COORD_BITS-1:0] pen_x_r, pen_x_nxt;
  logic [COORD_BITS-1:0] pen_y_r, pen_y_nxt;
  logic [COORD_BITS-1:0] base_x, base_y;
  logic [COORD_BITS-1:0] quad_x2, quad_y2;
  logic                  is_char, is_newline, draws;
  logic                  emit_valid_r;
  logic [2:0]            vtx_cnt_r;
  logic                  emit_free;
  logic                  s1_move;

  assign is_char    = s1_mode_r == tgq_pkg::MODE_CHAR;
  assign is_newline = s1_code_r == tgq_pkg::NEWLINE_CODE;
  assign draws      = is_char && !is_newline && s1_hit_r;

  // emitter takes a new quad when empty or while its sixth vertex is taken
  assign emit_free = !emit_valid_r || (out_ready && vtx_cnt_r == tgq_pkg::LAST_VERTEX);
  assign s1_move   = s1_valid_r && (!draws || emit_free);
  assign in_ready  = !s1_valid_r || s1_move;

  // string start resets the pen before anything else
  assign base_x  = s1_start_r ? origin_x_c : pen_x_r;
  assign base_y  = s1_start_r ? origin_y_c : pen_y_r;
  assign quad_x2 = base_x + COORD_BITS'(rd_entry_r.advance);
  assign quad_y2 = base_y + COORD_BITS'(line_height_r);

  always_comb begin
    pen_x_nxt = base_x;
    pen_y_nxt = base_y;
    if (is_newline) begin
      pen_x_nxt = origin_x_c;
      pen_y_nxt = base_y - COORD_BITS'(line_height_r);
    end else if (draws) begin
      pen_x_nxt = quad_x2 + COORD_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
    end else if (s1_move && is_char) begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
    end
  end

  // ------------------------------------------------------------------------
  // vertex emitter: quad corners held, one vertex per output request
  // ------------------------------------------------------------------------
  logic [15:0] q_x_r, q_x2_r, q_y_r, q_y2_r, q_ul_r, q_ur_r;
  tgq_pkg::corner_t corner;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_valid_r <= 1'b0;
      vtx_cnt_r    <= '0;
    end else if (s1_move && draws) begin
      emit_valid_r <= 1'b1;
      vtx_cnt_r    <= '0;
    end else if (emit_valid_r && out_ready) begin
      if (vtx_cnt_r == tgq_pkg::LAST_VERTEX) begin
        emit_valid_r <= 1'b0;
      end else begin
        vtx_cnt_r <= vtx_cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && draws) begin
      q_x_r  <= to_out(base_x);
      q_x2_r <= to_out(quad_x2);
      q_y_r  <= to_out(base_y);
      q_y2_r <= to_out(quad_y2);
      q_ul_r <= rd_entry_r.u_left;
      q_ur_r <= rd_entry_r.u_right;
    end
  end

  assign corner           = tgq_pkg::vertex_corner(vtx_cnt_r);
  assign out_valid        = emit_valid_r;
  assign out_vertex_x     = corner.right  ? q_x2_r : q_x_r;
  assign out_vertex_y     = corner.bottom ? q_y2_r : q_y_r;
  assign out_tex_u        = corner.right  ? q_ur_r : q_ul_r;
  assign out_tex_v        = corner.bottom ? tgq_pkg::V_ONE : tgq_pkg::V_ZERO;
  assign out_vertex_color = text_color_r;
  assign out_last         = vtx_cnt_r == tgq_pkg::LAST_VERTEX;

endmodule

@@ rtl/tgq_checker.sv @@
// ---------------------------------------------------------------------------
// tgq_checker - port-level checks for the text glyph quad generator
// watches reset, input holds, vertex groups and output stalls over time
// ---------------------------------------------------------------------------
module tgq_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [15:0]                 out_vertex_x,
  input logic signed [15:0]                 out_vertex_y,
  input logic [15:0]                        out_tex_u,
  input logic [15:0]                        out_tex_v,
  input logic                               out_last
);

  // nothing comes out in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("vertex shown right after reset");

  // a waiting input request is not withdrawn
  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input request dropped before accept");

  // a quad is sent without gaps until its sixth vertex
  a_group_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("vertex group broken before last vertex");

  // the sixth vertex sits on the bottom row
  a_last_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_tex_v == tgq_pkg::V_ONE)
    else $error("last vertex not on bottom row");

  // a stalled vertex keeps its position, U coordinate and last flag
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex_x)
      && $stable(out_vertex_y) && $stable(out_tex_u) && $stable(out_last))
    else $error("stalled vertex changed");

endmodule

bind text_glyph_quad_generator tgq_checker u_tgq_checker (.*);

@@ tb/sv/tb_text_glyph_quad_generator.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_text_glyph_quad_generator - self-checking bench for the glyph quad block
// loads glyph entries, streams text through the pen logic and compares every
// vertex against a local model of the pen, the glyph table and the registers
// ---------------------------------------------------------------------------
module tb_text_glyph_quad_generator;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE_CYCLES = 8;

  // one expected vertex, fields at the port widths
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] u;
    logic [15:0] v;
    logic [31:0] color;
    logic        last;
  } vertex_t;

  logic clk;
  logic rst_n;

  logic        in_valid;
  logic        in_ready;
  logic        in_mode;
  logic [7:0]  in_char_code;
  logic        in_string_start;
  logic [15:0] in_glyph_u_left;
  logic [15:0] in_glyph_u_right;
  logic [7:0]  in_glyph_advance;

  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_vertex_x;
  logic signed [15:0] out_vertex_y;
  logic [15:0]        out_tex_u;
  logic [15:0]        out_tex_v;
  logic [31:0]        out_vertex_color;
  logic               out_last;

  logic                               cfg_we;
  logic [tgq_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [tgq_pkg::CFG_DATA_BITS-1:0]  cfg_wdata;

  // local copy of the block: registers, glyph table and pen
  logic [15:0]           org_x;
  logic [15:0]           org_y;
  logic [7:0]            row_step;
  logic [31:0]           ink_color;
  logic                  glyph_loaded [256];
  tgq_pkg::glyph_entry_t glyph_tab [256];
  logic [7:0]            loaded_codes [$];
  logic [15:0]           pen_x;
  logic [15:0]           pen_y;

  vertex_t     vertex_q [$];
  vertex_t     want_vertex;
  int unsigned err_count;
  int unsigned vertex_count;
  int unsigned cycle_count = 0;

  // idling knobs, flipped per test phase
  logic gaps_on;
  logic stalls_on;

  text_glyph_quad_generator DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_char_code     (in_char_code),
    .in_string_start  (in_string_start),
    .in_glyph_u_left  (in_glyph_u_left),
    .in_glyph_u_right (in_glyph_u_right),
    .in_glyph_advance (in_glyph_advance),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_vertex_x     (out_vertex_x),
    .out_vertex_y     (out_vertex_y),
    .out_tex_u        (out_tex_u),
    .out_tex_v        (out_tex_v),
    .out_vertex_color (out_vertex_color),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("mismatch: vertex %0d %s got %h want %h", vertex_count, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch(what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // vertex checker: every accepted vertex is matched to the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (vertex_q.size() == 0) begin
        report_mismatch("unexpected", {16'b0, out_vertex_x}, 32'b0);
      end else begin
        want_vertex = vertex_q.pop_front();
        check_field("x",     {16'b0, out_vertex_x}, {16'b0, want_vertex.x});
        check_field("y",     {16'b0, out_vertex_y}, {16'b0, want_vertex.y});
        check_field("u",     {16'b0, out_tex_u},    {16'b0, want_vertex.u});
        check_field("v",     {16'b0, out_tex_v},    {16'b0, want_vertex.v});
        check_field("color", out_vertex_color,      want_vertex.color);
        check_field("last",  {31'b0, out_last},     {31'b0, want_vertex.last});
      end
      vertex_count++;
    end
  end

  // output side back-pressure: random stall bursts while enabled
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  function automatic void push_vertex(input logic [15:0] x, input logic [15:0] y,
                                      input logic [15:0] u, input logic [15:0] v,
                                      input logic last);
    vertex_t vtx;
    vtx.x     = x;
    vtx.y     = y;
    vtx.u     = u;
    vtx.v     = v;
    vtx.color = ink_color;
    vtx.last  = last;
    vertex_q.insert(vertex_q.size(), vtx);
  endfunction

  // ---------------------------------------------------------------------------
  // quad prediction for one accepted request; coordinates wrap at 16 bits
  // ---------------------------------------------------------------------------
  function automatic void predict_quad(input tgq_pkg::mode_t mode,
                                       input logic [7:0] code,
                                       input logic start, input logic [15:0] ul,
                                       input logic [15:0] ur, input logic [7:0] adv);
    tgq_pkg::glyph_entry_t g;
    logic [15:0]           x2;
    logic [15:0]           y2;
    if (mode == tgq_pkg::MODE_WRITE) begin
      // table load, string start flag has no effect here
      g.u_left  = ul;
      g.u_right = ur;
      g.advance = adv;
      glyph_tab[code] = g;
      if (!glyph_loaded[code])
        loaded_codes.insert(loaded_codes.size(), code);
      glyph_loaded[code] = 1'b1;
    end else begin
      if (start) begin
        pen_x = org_x;
        pen_y = org_y;
      end
      if (code == tgq_pkg::NEWLINE_CODE) begin
        // newline wins over any table entry at the same code
        pen_x = org_x;
        pen_y = pen_y - {8'b0, row_step};
      end else if (glyph_loaded[code]) begin
        g  = glyph_tab[code];
        x2 = pen_x + {8'b0, g.advance};
        y2 = pen_y + {8'b0, row_step};
        push_vertex(pen_x, pen_y, g.u_left,  tgq_pkg::V_ZERO, 1'b0);
        push_vertex(x2,    pen_y, g.u_right, tgq_pkg::V_ZERO, 1'b0);
        push_vertex(x2,    y2,    g.u_right, tgq_pkg::V_ONE,  1'b0);
        push_vertex(pen_x, pen_y, g.u_left,  tgq_pkg::V_ZERO, 1'b0);
        push_vertex(x2,    y2,    g.u_right, tgq_pkg::V_ONE,  1'b0);
        push_vertex(pen_x, y2,    g.u_left,  tgq_pkg::V_ONE,  1'b1);
        pen_x = x2 + 16'd1;
      end
      // unknown glyph: skipped, pen stays
    end
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: optional idle burst, present, hold until accepted
  // ---------------------------------------------------------------------------
  task automatic send_request(input tgq_pkg::mode_t mode, input logic [7:0] code,
                              input logic start, input logic [15:0] ul,
                              input logic [15:0] ur, input logic [7:0] adv);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid         = 1'b1;
    in_mode          = mode;
    in_char_code     = code;
    in_string_start  = start;
    in_glyph_u_left  = ul;
    in_glyph_u_right = ur;
    in_glyph_advance = adv;
    @(posedge clk);
    while (in_ready !== 1'b1)
      @(posedge clk);
    predict_quad(mode, code, start, ul, ur, adv);
    @(negedge clk);
  endtask

  task automatic load_glyph(input logic [7:0] code, input logic [15:0] ul,
                            input logic [15:0] ur, input logic [7:0] adv,
                            input logic start);
    send_request(tgq_pkg::MODE_WRITE, code, start, ul, ur, adv);
  endtask

  // character request; the glyph fields are don't-care, so they carry noise
  task automatic put_char(input logic [7:0] code, input logic start);
    send_request(tgq_pkg::MODE_CHAR, code, start, 16'($urandom), 16'($urandom),
                 8'($urandom));
  endtask

  // drop valid and wait until every vertex is out, then let loads and
  // skipped characters still in the pipe drain before touching registers
  task automatic wait_drained();
    in_valid = 1'b0;
    while (vertex_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input tgq_pkg::cfg_reg_t idx, input logic [31:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      tgq_pkg::REG_ORIGIN_X:    org_x     = data[15:0];
      tgq_pkg::REG_ORIGIN_Y:    org_y     = data[15:0];
      tgq_pkg::REG_LINE_HEIGHT: row_step  = data[7:0];
      tgq_pkg::REG_TEXT_COLOR:  ink_color = data;
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input logic [15:0] ox, input logic [15:0] oy,
                                input logic [7:0] lh, input logic [31:0] color);
    wait_drained();
    write_reg(tgq_pkg::REG_ORIGIN_X, {16'b0, ox});
    write_reg(tgq_pkg::REG_ORIGIN_Y, {16'b0, oy});
    write_reg(tgq_pkg::REG_LINE_HEIGHT, {24'b0, lh});
    write_reg(tgq_pkg::REG_TEXT_COLOR, color);
  endtask

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // unknown glyph is skipped, then the first loaded glyph at the reset origin
  task automatic test_first_glyph();
    put_char(8'h41, 1'b1);
    load_glyph(8'h41, 16'h0000, tgq_pkg::V_ONE, 8'd7, 1'b0);
    put_char(8'h41, 1'b1);
    put_char(8'h41, 1'b0);
  endtask

  // field extremes: zero width, full width, U past 1.0, start flag on a load
  task automatic test_glyph_extremes();
    load_glyph(8'd0, 16'h0000, 16'h0000, 8'd0, 1'b1);
    load_glyph(8'd255, tgq_pkg::V_ONE, tgq_pkg::V_ONE, 8'd255, 1'b0);
    load_glyph(8'd1, 16'hFFFF, 16'hFFFF, 8'd128, 1'b0);
    put_char(8'd0, 1'b1);
    put_char(8'd255, 1'b0);
    put_char(8'd1, 1'b0);
  endtask

  // newline ignores a table entry at its own code, with and without start
  task automatic test_newline();
    load_glyph(tgq_pkg::NEWLINE_CODE, 16'h1234, 16'h4321, 8'd9, 1'b0);
    put_char(8'h41, 1'b1);
    put_char(tgq_pkg::NEWLINE_CODE, 1'b0);
    put_char(8'h41, 1'b0);
    put_char(tgq_pkg::NEWLINE_CODE, 1'b0);
    put_char(tgq_pkg::NEWLINE_CODE, 1'b1);
    put_char(8'h41, 1'b0);
  endtask

  // overwriting an entry takes effect on the next draw
  task automatic test_reload();
    load_glyph(8'h41, 16'h2000, 16'h3000, 8'd3, 1'b0);
    put_char(8'h41, 1'b1);
  endtask

  // register extremes: coordinate wrap both ways, tallest and flattest quads
  task automatic test_config_extremes();
    write_all_regs(16'h7FFF, 16'h8000, 8'd255, 32'h0000_0000);
    put_char(8'd255, 1'b1);
    put_char(tgq_pkg::NEWLINE_CODE, 1'b0);
    put_char(8'd1, 1'b0);
    write_all_regs(16'h8000, 16'h7FFF, 8'd1, 32'hA5A5_5A5A);
    put_char(8'h41, 1'b1);
    put_char(tgq_pkg::NEWLINE_CODE, 1'b0);
    put_char(8'h41, 1'b0);
    // zero height: flat quads and a newline that stays on the row
    wait_drained();
    write_reg(tgq_pkg::REG_LINE_HEIGHT, 32'd0);
    put_char(8'h41, 1'b1);
    put_char(tgq_pkg::NEWLINE_CODE, 1'b0);
    put_char(8'h41, 1'b0);
    write_all_regs(tgq_pkg::ORIGIN_X_RESET, tgq_pkg::ORIGIN_Y_RESET,
                   tgq_pkg::LINE_HEIGHT_RESET, tgq_pkg::TEXT_COLOR_RESET);
  endtask

  // ---------------------------------------------------------------------------
  // random text: strings of loaded glyphs with newlines, loads mixed in,
  // plus a little noise (random codes, stray string starts)
  // ---------------------------------------------------------------------------
  task automatic test_random_text();
    int unsigned phase;
    int unsigned n;
    int unsigned pick;
    int unsigned chars_left;
    logic [7:0]  code;
    chars_left = 0;
    for (phase = 0; phase < 6; phase++) begin
      // every phase change waits for all vertices first
      case (phase)
        1: write_all_regs(16'h7FFF, 16'h7FFF, 8'd255, 32'hFFFF_FFFF);
        2: write_all_regs(16'h8000, 16'h8000, 8'd1, 32'h0000_0000);
        default: write_all_regs(16'($urandom), 16'($urandom), 8'($urandom_range(1, 255)),
                                $urandom);
      endcase
      // phase 2 runs without idling, the last two only with output stalls or none
      gaps_on   = (phase < 2) || (phase == 3);
      stalls_on = (phase != 2) && (phase < 5);
      chars_left = 0;
      for (n = 0; n < 24; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8 || loaded_codes.size() == 0) begin
          load_glyph(8'($urandom), 16'($urandom_range(0, 32768)),
                     16'($urandom_range(0, 32768)), 8'($urandom), 1'($urandom));
        end else if (pick < 16) begin
          put_char(8'($urandom), 1'($urandom));
        end else if (pick < 26) begin
          put_char(tgq_pkg::NEWLINE_CODE, ($urandom_range(0, 7) == 0));
        end else begin
          code = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
          if (chars_left == 0) begin
            chars_left = $urandom_range(1, 12);
            put_char(code, 1'b1);
          end else begin
            put_char(code, 1'b0);
          end
          chars_left--;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_mode          = tgq_pkg::MODE_WRITE;
    in_char_code     = 8'd0;
    in_string_start  = 1'b0;
    in_glyph_u_left  = 16'd0;
    in_glyph_u_right = 16'd0;
    in_glyph_advance = 8'd0;
    cfg_we           = 1'b0;
    cfg_index        = tgq_pkg::REG_ORIGIN_X;
    cfg_wdata        = '0;
    gaps_on          = 1'b1;
    stalls_on        = 1'b1;
    err_count        = 0;
    vertex_count     = 0;

    org_x     = tgq_pkg::ORIGIN_X_RESET;
    org_y     = tgq_pkg::ORIGIN_Y_RESET;
    row_step  = tgq_pkg::LINE_HEIGHT_RESET;
    ink_color = tgq_pkg::TEXT_COLOR_RESET;
    pen_x     = 16'd0;
    pen_y     = 16'd0;
    for (int i = 0; i < 256; i++) begin
      glyph_loaded[i] = 1'b0;
      glyph_tab[i]    = '0;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_first_glyph();
    test_glyph_extremes();
    test_newline();
    test_reload();
    test_config_extremes();
    test_random_text();

    // wind down: no idling, wait for the last vertex, then watch for extras
    in_valid  = 1'b0;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    while (vertex_q.size() != 0)
      @(negedge clk);
    repeat (4 * SETTLE_CYCLES) @(negedge clk);

    if (err_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
